/* rtl/fun_pkg.sv */
// Package for the face unit normal block: field widths and parameter defaults.
// Used by every module under rtl/.
package fun_pkg;

  localparam int FIELD_W               = 16;  // width of each vertex coordinate field
  localparam int OUT_W                 = 16;  // width of each normal component field
  localparam int COORD_WIDTH_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF  = 14;
  localparam int IN_TDATA_W            = 9 * FIELD_W;
  localparam int OUT_TDATA_W           = 3 * OUT_W;

  localparam logic [31:0] OUT_POS_MAX  = 32'd32767;
  localparam logic [31:0] OUT_NEG_MAX  = 32'd32768;

endpackage

/* rtl/fun_front.sv */
// Front pipeline: edges, cross product, magnitudes and squared length.
// Five register stages; depends on fun_pkg.
module fun_front import fun_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int MW = 2 * CW + 1,
  parameter int RW = MW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_TDATA_W-1:0] in_data,
  output logic                 out_valid,
  output logic [2*RW-1:0]      out_rad,
  output logic [3*MW-1:0]      out_mag,
  output logic [2:0]           out_neg,
  output logic                 out_zero
);

  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = PW + 1;
  localparam int SQW = 2 * MW;

  logic [4:0] vld;

  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [PW-1:0] p  [6];
  logic [MW-1:0]        mag3 [3];
  logic [2:0]           neg3;
  logic                 zero3;
  logic [SQW-1:0]       sq [3];
  logic [MW-1:0]        mag4 [3];
  logic [2:0]           neg4;
  logic                 zero4;

  logic signed [CW-1:0] crd [9];
  logic signed [NW-1:0] nn  [3];
  logic [NW-1:0]        nabs [3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      crd[k] = $signed(CW'({{CW{1'b0}}, in_data[k*FIELD_W +: FIELD_W]}));
    end
    nn[0] = NW'(p[0]) - NW'(p[1]);
    nn[1] = NW'(p[2]) - NW'(p[3]);
    nn[2] = NW'(p[4]) - NW'(p[5]);
    for (int j = 0; j < 3; j++) begin
      nabs[j] = nn[j][NW-1] ? NW'(-nn[j]) : NW'(nn[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edges e0 = C - B, e1 = A - B
      for (int j = 0; j < 3; j++) begin
        e0[j] <= EW'(crd[6+j]) - EW'(crd[3+j]);
        e1[j] <= EW'(crd[j]) - EW'(crd[3+j]);
      end
      // cross product partial products
      p[0] <= PW'(e0[1]) * PW'(e1[2]);
      p[1] <= PW'(e0[2]) * PW'(e1[1]);
      p[2] <= PW'(e0[2]) * PW'(e1[0]);
      p[3] <= PW'(e0[0]) * PW'(e1[2]);
      p[4] <= PW'(e0[0]) * PW'(e1[1]);
      p[5] <= PW'(e0[1]) * PW'(e1[0]);
      // components as sign and magnitude
      for (int j = 0; j < 3; j++) begin
        mag3[j] <= nabs[j][MW-1:0];
        neg3[j] <= nn[j][NW-1];
      end
      zero3 <= (nn[0] == '0) && (nn[1] == '0) && (nn[2] == '0);
      // squares
      for (int j = 0; j < 3; j++) begin
        sq[j]   <= SQW'(mag3[j]) * SQW'(mag3[j]);
        mag4[j] <= mag3[j];
      end
      neg4  <= neg3;
      zero4 <= zero3;
      // squared length
      out_rad <= (2*RW)'(sq[0]) + (2*RW)'(sq[1]) + (2*RW)'(sq[2]);
      out_mag <= {mag4[2], mag4[1], mag4[0]};
      out_neg <= neg4;
      out_zero <= zero4;
    end
  end

  assign out_valid = vld[4];

endmodule

/* rtl/fun_sqrt_cell.sv */
// One digit cell of the pipelined integer square root: settles one root bit.
// Carries side data along; depends on fun_pkg.
module fun_sqrt_cell import fun_pkg::*; #(
  parameter int RW    = 2 * COORD_WIDTH_DEF + 2,
  parameter int SIDEW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [RW:0]       in_rem,
  input  logic [RW-1:0]     in_root,
  input  logic [SIDEW-1:0]  in_side,
  output logic              out_valid,
  output logic [2*RW-1:0]   out_rad,
  output logic [RW:0]       out_rem,
  output logic [RW-1:0]     out_root,
  output logic [SIDEW-1:0]  out_side
);

  logic [RW+2:0] cur;
  logic [RW+2:0] trial;
  logic [RW+3:0] diff;
  logic          fits;

  always_comb begin
    cur   = {in_rem, in_rad[2*RW-1 -: 2]};
    trial = {1'b0, in_root, 2'b01};
    diff  = {1'b0, cur} - {1'b0, trial};
    fits  = !diff[RW+3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[2*RW-3:0], 2'b00};
      out_rem  <= fits ? diff[RW:0] : cur[RW:0];
      out_root <= {in_root[RW-2:0], fits};
      out_side <= in_side;
    end
  end

endmodule

/* rtl/fun_div_cell.sv */
// One quotient-bit cell of the pipelined divider, three components in parallel.
// Depends on fun_pkg.
module fun_div_cell import fun_pkg::*; #(
  parameter int RW = 2 * COORD_WIDTH_DEF + 2,
  parameter int QW = NORMAL_FRAC_BITS_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RW-1:0]     in_len,
  input  logic [3*(RW+1)-1:0] in_rem,
  input  logic [3*QW-1:0]   in_quo,
  input  logic [3:0]        in_flags,   // neg x, y, z, zero
  output logic              out_valid,
  output logic [RW-1:0]     out_len,
  output logic [3*(RW+1)-1:0] out_rem,
  output logic [3*QW-1:0]   out_quo,
  output logic [3:0]        out_flags
);

  logic [RW:0]   r    [3];
  logic [RW:0]   rsub [3];
  logic [QW-1:0] q    [3];
  logic          ge   [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r[j]    = in_rem[j*(RW+1) +: RW+1];
      q[j]    = in_quo[j*QW +: QW];
      ge[j]   = r[j] >= {1'b0, in_len};
      rsub[j] = ge[j] ? r[j] - {1'b0, in_len} : r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_len   <= in_len;
      out_flags <= in_flags;
      for (int j = 0; j < 3; j++) begin
        out_rem[j*(RW+1) +: RW+1] <= {rsub[j][RW-1:0], 1'b0};
        out_quo[j*QW +: QW]       <= {q[j][QW-2:0], ge[j]};
      end
    end
  end

endmodule

/* rtl/face_unit_normal.sv */
// Top level of the face unit normal block: front, square root chain, divider chain.
// Depends on fun_pkg, fun_front, fun_sqrt_cell and fun_div_cell.
//
// Usage:
//   s_* channel: one transaction carries a triangle A, B, C as nine signed
//   coordinates (low COORD_WIDTH bits of each 16-bit field are used).
//   m_* channel: one transaction carries the unit normal in signed Q1.14
//   (more generally NORMAL_FRAC_BITS fraction bits), truncated toward zero,
//   and the degenerate flag in tuser (normal forced to zero).
//   Throughput: one face per cycle unless a stall holds the row. The
//   pipeline is a row of cells: five front stages (edges, cross product,
//   magnitudes, squares, sum), one square root cell per root bit
//   (2*COORD_WIDTH+2 cells), one divider cell per quotient bit
//   (NORMAL_FRAC_BITS+1 cells) and one output register.
//   Stall: when the output register holds a result that m_tready does not
//   take, the whole row holds and s_tready drops; a new transaction is
//   accepted in the same cycle in which a waiting result is taken.
//   Reset: rst clears every valid bit; no other register is reset.
module face_unit_normal import fun_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, lowest first)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // normal_x, normal_y, normal_z (16 bits each, lowest first)
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // degenerate
  output logic                   m_tuser
);

  localparam int MW    = 2 * COORD_WIDTH + 1;   // component magnitude width
  localparam int RW    = MW + 1;                // root width
  localparam int QW    = NORMAL_FRAC_BITS + 1;  // quotient width
  localparam int SIDEW = 3 * MW + 4;            // magnitudes, signs, zero flag

  logic en;

  // advance the whole row whenever the output register can take a result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front stages
  logic              f_valid;
  logic [2*RW-1:0]   f_rad;
  logic [3*MW-1:0]   f_mag;
  logic [2:0]        f_neg;
  logic              f_zero;

  fun_front #(.CW(COORD_WIDTH), .MW(MW), .RW(RW)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_data(s_tdata),
    .out_valid(f_valid), .out_rad(f_rad), .out_mag(f_mag),
    .out_neg(f_neg), .out_zero(f_zero)
  );

  // square root chain: one cell per root bit, most significant first
  logic              sq_valid [RW+1];
  logic [2*RW-1:0]   sq_rad   [RW+1];
  logic [RW:0]       sq_rem   [RW+1];
  logic [RW-1:0]     sq_root  [RW+1];
  logic [SIDEW-1:0]  sq_side  [RW+1];

  assign sq_valid[0] = f_valid;
  assign sq_rad[0]   = f_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = {f_zero, f_neg, f_mag};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    fun_sqrt_cell #(.RW(RW), .SIDEW(SIDEW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sq_valid[i]), .in_rad(sq_rad[i]), .in_rem(sq_rem[i]),
      .in_root(sq_root[i]), .in_side(sq_side[i]),
      .out_valid(sq_valid[i+1]), .out_rad(sq_rad[i+1]), .out_rem(sq_rem[i+1]),
      .out_root(sq_root[i+1]), .out_side(sq_side[i+1])
    );
  end

  // divider chain: seed remainders with the magnitudes, |n| <= length
  logic                  dv_valid [QW+1];
  logic [RW-1:0]         dv_len   [QW+1];
  logic [3*(RW+1)-1:0]   dv_rem   [QW+1];
  logic [3*QW-1:0]       dv_quo   [QW+1];
  logic [3:0]            dv_flags [QW+1];

  assign dv_valid[0] = sq_valid[RW];
  assign dv_len[0]   = sq_root[RW];
  assign dv_quo[0]   = '0;
  assign dv_flags[0] = sq_side[RW][SIDEW-1 -: 4];

  for (genvar j = 0; j < 3; j++) begin : g_seed
    assign dv_rem[0][j*(RW+1) +: RW+1] = {2'b00, sq_side[RW][j*MW +: MW]};
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    fun_div_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv_valid[i]), .in_len(dv_len[i]), .in_rem(dv_rem[i]),
      .in_quo(dv_quo[i]), .in_flags(dv_flags[i]),
      .out_valid(dv_valid[i+1]), .out_len(dv_len[i+1]), .out_rem(dv_rem[i+1]),
      .out_quo(dv_quo[i+1]), .out_flags(dv_flags[i+1])
    );
  end

  // output stage: apply sign, saturate, force zero for a degenerate face
  logic [31:0]       qx   [3];
  logic [31:0]       qsat [3];
  logic [OUT_W-1:0]  comp [3];
  logic              deg;

  always_comb begin
    deg = dv_flags[QW][3];
    for (int j = 0; j < 3; j++) begin
      qx[j] = 32'(dv_quo[QW][j*QW +: QW]);
      if (dv_flags[QW][j]) begin
        qsat[j] = (qx[j] > OUT_NEG_MAX) ? OUT_NEG_MAX : qx[j];
        comp[j] = OUT_W'(32'd0 - qsat[j]);
      end else begin
        qsat[j] = (qx[j] > OUT_POS_MAX) ? OUT_POS_MAX : qx[j];
        comp[j] = OUT_W'(qsat[j]);
      end
      if (deg) begin
        comp[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {comp[2], comp[1], comp[0]};
      m_tuser <= deg;
    end
  end

endmodule
